[rtl/bate_pkg.sv]
`timescale 1ns / 1ps

package bate_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 3;
	localparam int POS_W    = 5;
	localparam int STAT_W   = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT_AT     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT_SORTED = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE_AT     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE_FIRST  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE_ALL    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SHOW          = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [CNT_W-1:0]         count;
		logic signed [DATA_W-1:0] element;
		logic                     last;
	} result_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_SCAN,
		OP_UP_INIT_POS,
		OP_UP_INIT_SCAN,
		OP_UP_STEP,
		OP_UP_FINISH,
		OP_DOWN_INIT_POS,
		OP_DOWN_INIT_SCAN,
		OP_DOWN_STEP,
		OP_DOWN_FINISH,
		OP_COMPACT_STEP,
		OP_COMPACT_FINISH,
		OP_SHOW_STEP
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_SORT,
		S_SCAN_FIRST,
		S_UP,
		S_DOWN,
		S_COMPACT,
		S_SHOW,
		S_REPORT
	} ctl_state_t;

	typedef struct packed {
		dp_op_t            op;
		logic              emit;
		logic [STAT_W-1:0] status;
		logic              show_elem;
		logic              last;
	} ctl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             i_lt_cnt;
		logic             i_lt_cap;
		logic             rd_gt_val;
		logic             rd_eq_val;
		logic             pos_bad_ins;
		logic             pos_bad_del;
		logic             up_more;
		logic             down_more;
		logic             show_last;
		logic             j_eq_cnt;
		logic             cnt_zero;
	} dp_stat_t;

endpackage

[rtl/bate_ctrl.sv]
`timescale 1ns / 1ps

module bate_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bate_pkg::dp_stat_t stat,
	output bate_pkg::ctl_cmd_t ctl
);
	import bate_pkg::*;

	ctl_state_t        state_q, state_d;
	logic [STAT_W-1:0] st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		st_d          = st_q;
		ctl.op        = OP_IDLE;
		ctl.emit      = 1'b0;
		ctl.status    = ST_OK;
		ctl.show_elem = 1'b0;
		ctl.last      = 1'b1;
		busy          = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op  = OP_LOAD;
					st_d    = ST_OK;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_INSERT_AT: begin
						if (stat.pos_bad_ins) begin
							st_d    = ST_BAD_POS;
							state_d = S_REPORT;
						end else begin
							ctl.op  = OP_UP_INIT_POS;
							state_d = S_UP;
						end
					end
					CMD_INSERT_SORTED: state_d = S_SCAN_SORT;
					CMD_DELETE_AT: begin
						if (stat.pos_bad_del) begin
							st_d    = ST_BAD_POS;
							state_d = S_REPORT;
						end else begin
							ctl.op  = OP_DOWN_INIT_POS;
							state_d = S_DOWN;
						end
					end
					CMD_DELETE_FIRST: state_d = S_SCAN_FIRST;
					CMD_DELETE_ALL:   state_d = S_COMPACT;
					CMD_SHOW: begin
						if (stat.cnt_zero) begin
							ctl.emit   = 1'b1;
							ctl.status = ST_EMPTY;
							state_d    = S_IDLE;
						end else begin
							state_d = S_SHOW;
						end
					end
					default: state_d = S_REPORT;
				endcase
			end
			S_SCAN_SORT: begin
				if (stat.i_lt_cnt && !stat.rd_gt_val) begin
					ctl.op = OP_SCAN;
				end else if (stat.i_lt_cap) begin
					ctl.op  = OP_UP_INIT_SCAN;
					state_d = S_UP;
				end else begin
					// full and no smaller slot: ignored
					state_d = S_REPORT;
				end
			end
			S_UP: begin
				if (stat.up_more) begin
					ctl.op = OP_UP_STEP;
				end else begin
					ctl.op  = OP_UP_FINISH;
					state_d = S_REPORT;
				end
			end
			S_SCAN_FIRST: begin
				if (stat.i_lt_cnt && !stat.rd_eq_val) begin
					ctl.op = OP_SCAN;
				end else if (stat.i_lt_cnt) begin
					ctl.op  = OP_DOWN_INIT_SCAN;
					state_d = S_DOWN;
				end else begin
					st_d    = ST_NOT_FOUND;
					state_d = S_REPORT;
				end
			end
			S_DOWN: begin
				if (stat.down_more) begin
					ctl.op = OP_DOWN_STEP;
				end else begin
					ctl.op  = OP_DOWN_FINISH;
					state_d = S_REPORT;
				end
			end
			S_COMPACT: begin
				if (stat.i_lt_cnt) begin
					ctl.op = OP_COMPACT_STEP;
				end else begin
					ctl.op  = OP_COMPACT_FINISH;
					st_d    = stat.j_eq_cnt ? ST_NOT_FOUND : ST_OK;
					state_d = S_REPORT;
				end
			end
			S_SHOW: begin
				ctl.op        = OP_SHOW_STEP;
				ctl.emit      = 1'b1;
				ctl.show_elem = 1'b1;
				ctl.last      = stat.show_last;
				if (stat.show_last) begin
					state_d = S_IDLE;
				end
			end
			S_REPORT: begin
				ctl.emit   = 1'b1;
				ctl.status = st_q;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[rtl/bate_dpath.sv]
`timescale 1ns / 1ps

module bate_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  bate_pkg::request_t request,
	input  bate_pkg::ctl_cmd_t ctl,
	output bate_pkg::dp_stat_t stat,
	output logic               result_valid,
	output bate_pkg::result_t  result
);
	import bate_pkg::*;

	logic signed [DATA_W-1:0] mem [CAPACITY];

	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         i_q;
	logic [CNT_W-1:0]         j_q;
	logic [CNT_W-1:0]         tgt_q;
	logic [CMD_W-1:0]         cmd_q;
	logic signed [DATA_W-1:0] val_q;
	logic [POS_W-1:0]         pos_q;
	logic                     res_valid_q;
	result_t                  res_q;
	logic signed [DATA_W-1:0] rd_q;
	logic [IDX_W-1:0]         rd_off_q;

	logic [CNT_W-1:0]         i_d;
	logic [IDX_W-1:0]         rd_off_d;
	logic [IDX_W-1:0]         rd_addr;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic [CNT_W-1:0]         up_start;
	logic [CNT_W:0]           i_inc;
	logic [CNT_W-1:0]         cap_c;

	assign cap_c    = CNT_W'(CAPACITY);
	assign up_start = (cnt_q < cap_c) ? cnt_q : CNT_W'(CAPACITY - 1);
	assign i_inc    = {1'b0, i_q} + (CNT_W + 1)'(1);

	// next pointer, and the neighbour offset the following steps read at
	always_comb begin
		i_d      = i_q;
		rd_off_d = rd_off_q;
		case (ctl.op)
			OP_LOAD: begin
				i_d      = '0;
				rd_off_d = '0;
			end
			OP_SCAN, OP_SHOW_STEP, OP_DOWN_STEP, OP_COMPACT_STEP: i_d = i_q + CNT_W'(1);
			OP_UP_INIT_POS, OP_UP_INIT_SCAN: begin
				i_d      = up_start;
				rd_off_d = '1;
			end
			OP_UP_STEP: i_d = i_q - CNT_W'(1);
			OP_DOWN_INIT_POS: begin
				i_d      = CNT_W'(pos_q - POS_W'(1));
				rd_off_d = IDX_W'(1);
			end
			OP_DOWN_INIT_SCAN: rd_off_d = IDX_W'(1);
			default: ;
		endcase
	end

	// one read a cycle: the neighbour during shifts, else the scan pointer;
	// the read is registered so the address comes from the next pointer
	assign rd_addr = i_d[IDX_W-1:0] + rd_off_d;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = i_q[IDX_W-1:0];
		wr_data = rd_q;
		case (ctl.op)
			OP_UP_STEP, OP_DOWN_STEP: wr_en = 1'b1;
			OP_UP_FINISH: begin
				wr_en   = 1'b1;
				wr_addr = tgt_q[IDX_W-1:0];
				wr_data = val_q;
			end
			OP_COMPACT_STEP: begin
				wr_en   = (rd_q != val_q);
				wr_addr = j_q[IDX_W-1:0];
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				cmd_q <= request.cmd;
				val_q <= request.value;
				pos_q <= request.position;
			end
			OP_UP_INIT_POS:  tgt_q <= CNT_W'(pos_q - POS_W'(1));
			OP_UP_INIT_SCAN: tgt_q <= i_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			rd_off_q <= '0;
		end else begin
			i_q      <= i_d;
			rd_off_q <= rd_off_d;
			case (ctl.op)
				OP_LOAD: j_q <= '0;
				OP_UP_FINISH: begin
					if (cnt_q < cap_c) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				OP_DOWN_FINISH: cnt_q <= cnt_q - CNT_W'(1);
				OP_COMPACT_STEP: begin
					if (rd_q != val_q) begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				OP_COMPACT_FINISH: cnt_q <= j_q;
				default: ;
			endcase
		end
	end

	always_comb begin
		stat.cmd         = cmd_q;
		stat.i_lt_cnt    = (i_q < cnt_q);
		stat.i_lt_cap    = (i_q < cap_c);
		stat.rd_gt_val   = (rd_q > val_q);
		stat.rd_eq_val   = (rd_q == val_q);
		stat.pos_bad_ins = (pos_q == '0)
			|| ({1'b0, pos_q} > ({1'b0, cnt_q} + (CNT_W + 1)'(1)))
			|| ({1'b0, pos_q} > (CNT_W + 1)'(CAPACITY));
		stat.pos_bad_del = (pos_q == '0) || ({1'b0, pos_q} > {1'b0, cnt_q});
		stat.up_more     = (i_q > tgt_q);
		stat.down_more   = (i_inc < {1'b0, cnt_q});
		stat.show_last   = (i_inc == {1'b0, cnt_q});
		stat.j_eq_cnt    = (j_q == cnt_q);
		stat.cnt_zero    = (cnt_q == '0);
	end

	// result register: one beat per emit, count taken after the command has settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_q.status  <= ctl.status;
			res_q.count   <= cnt_q;
			res_q.element <= ctl.show_elem ? rd_q : '0;
			res_q.last    <= ctl.last;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

[rtl/bounded_array_table_engine_core.sv]
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------
// request   | start & !busy        | request_t: cmd, value, position
// result    | result_valid strobe  | result_t: status, count, element, last
//
// each command walks the table one entry a cycle through a single registered
// read port; a search and the shift after it cover the table once between them.
// results are registered and appear in the cycle after the step that makes them;
// the last beat can coincide with busy going low. reset clears the count and
// control, not the table. results are strobes and cannot be stalled.

module bounded_array_table_engine_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bate_pkg::request_t request,
	output logic               result_valid,
	output bate_pkg::result_t  result
);
	import bate_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t stat;

	bate_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	bate_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.ctl          (ctl),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.count <= CNT_W'(CAPACITY)))
		else $error("count above capacity");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != ST_OK) |-> result.last && (result.element == '0))
		else $error("error result not a single zero beat");

	a_mid_show_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("show stream broken off");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not start");

endmodule
